>>> rtl/core/ela_pkg.sv
`default_nettype none

package ela_pkg;

  // Register map, indexed by paddr[3:2]
  typedef enum logic [1:0] {
    REG_DIR  = 2'd0,
    REG_WIDE = 2'd1,
    REG_GAIN = 2'd2,
    REG_LINE = 2'd3
  } reg_idx_t;

  // Neighbor difference selection; the unused code acts as both combined
  typedef enum logic [1:0] {
    DIR_H    = 2'd0,
    DIR_V    = 2'd1,
    DIR_BOTH = 2'd2
  } dir_t;

  localparam int          NUM_CH   = 4;
  localparam int          CH_W     = 16;
  localparam int          DIFF_W   = CH_W + 2;
  localparam int          GAIN_W   = 16;
  localparam int          PROD_W   = DIFF_W + GAIN_W;
  localparam int          LINE_W   = 13;
  localparam logic [15:0] MAX_NARROW = 16'd255;
  localparam logic [15:0] MAX_WIDE   = 16'd65535;
  localparam logic [12:0] LINE_MIN = 13'd2;

  // Settings shared by all channel lanes
  typedef struct packed {
    logic                     wide;
    logic [1:0]               mode;
    logic signed [GAIN_W-1:0] gain;
  } lane_cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/emboss_layer_accumulate.sv
// Emboss layer accumulator.
// Pixel channel: pix_valid/pix_ready carry one word per pixel in raster order:
// frame_start, four source channels and the four current destination channels.
// Result channel: res_valid/res_ready carry the updated, clamped destination
// channels out_ch0..out_ch3. Pixels in the first row or first column of a
// frame only load the left register and the line buffer and give no word.
// Throughput: one pixel per cycle while no result word stalls. A producing
// pixel passes the line buffer read, multiply stage and clamp/output register
// before it appears on res_valid. The four channels run in parallel lanes.
// Stall: when a word waits on res_valid without res_ready, the whole pipeline
// holds and pix_ready drops; otherwise a new pixel is taken every cycle.
// Reset (rst, synchronous): clears registers to their defaults, the left
// pixel, column count and first-row flag, and empties the pipeline. The line
// buffer is not cleared; each read that feeds a result hits the row above.
// Configuration: APB port, registers at 0x0 direction, 0x4 wide channels,
// 0x8 strength, 0xC line width; write only while the block is idle.
`default_nettype none

module emboss_layer_accumulate #(
  parameter int MAX_LINE = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // pixel channel
  input  wire logic        pix_valid,
  output logic             pix_ready,
  input  wire logic        frame_start,
  input  wire logic [15:0] src_ch0,
  input  wire logic [15:0] src_ch1,
  input  wire logic [15:0] src_ch2,
  input  wire logic [15:0] src_ch3,
  input  wire logic [15:0] dst_ch0,
  input  wire logic [15:0] dst_ch1,
  input  wire logic [15:0] dst_ch2,
  input  wire logic [15:0] dst_ch3,
  // result channel
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [15:0]      out_ch0,
  output logic [15:0]      out_ch1,
  output logic [15:0]      out_ch2,
  output logic [15:0]      out_ch3
);

  localparam int COL_W = $clog2(MAX_LINE);
  localparam int NCH   = ela_pkg::NUM_CH;
  localparam int PIX_W = NCH * ela_pkg::CH_W;

  // configuration registers
  logic [1:0]                  direction_mode;
  logic                        wide_channels;
  logic [15:0]                 strength;
  logic [ela_pkg::LINE_W-1:0]  line_width;

  // neighbor state
  logic [PIX_W-1:0]  left_pixel;
  logic [COL_W-1:0]  column_count;
  logic              past_first_row;

  // pipeline
  logic              adv;
  logic              accept;
  logic              v1;
  logic              v2;
  logic [PIX_W-1:0]  src_word;
  logic [PIX_W-1:0]  src_m;
  logic [PIX_W-1:0]  dst_word;
  logic [PIX_W-1:0]  s1_src;
  logic [PIX_W-1:0]  s1_left;
  logic [PIX_W-1:0]  s1_dst;
  logic [PIX_W-1:0]  above_word;
  logic [15:0]       lane_out [NCH];
  ela_pkg::lane_cfg_t lane_cfg;

  // column tracking
  logic [COL_W-1:0]  col_cur;
  logic              first_ok;
  logic              produce;
  logic [31:0]       eff_w;
  logic [31:0]       col_inc;
  logic              wrap;
  logic              cfg_wr;

  // APB write and readback
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction_mode <= 2'(ela_pkg::DIR_H);
      wide_channels  <= 1'b0;
      strength       <= '0;
      line_width     <= ela_pkg::LINE_MIN;
    end else if (cfg_wr) begin
      case (ela_pkg::reg_idx_t'(paddr[3:2]))
        ela_pkg::REG_DIR:  direction_mode <= pwdata[1:0];
        ela_pkg::REG_WIDE: wide_channels  <= pwdata[0];
        ela_pkg::REG_GAIN: strength       <= pwdata[15:0];
        ela_pkg::REG_LINE: line_width     <= pwdata[ela_pkg::LINE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ela_pkg::reg_idx_t'(paddr[3:2]))
      ela_pkg::REG_DIR:  prdata = {30'd0, direction_mode};
      ela_pkg::REG_WIDE: prdata = {31'd0, wide_channels};
      ela_pkg::REG_GAIN: prdata = {16'd0, strength};
      ela_pkg::REG_LINE: prdata = {{(32-ela_pkg::LINE_W){1'b0}}, line_width};
      default:           prdata = '0;
    endcase
  end

  // handshake: the pipeline moves unless a result word is stalled
  assign adv       = !res_valid || res_ready;
  assign pix_ready = adv;
  assign accept    = pix_valid && pix_ready;

  // input word and channel masking for storage
  assign src_word = {src_ch3, src_ch2, src_ch1, src_ch0};
  assign dst_word = {dst_ch3, dst_ch2, dst_ch1, dst_ch0};
  assign src_m    = wide_channels ? src_word
                                  : (src_word & {NCH{16'h00FF}});

  // column and row position
  always_comb begin
    col_cur  = frame_start ? '0 : column_count;
    first_ok = frame_start ? 1'b0 : past_first_row;
    produce  = first_ok && (col_cur != '0);
    eff_w    = 32'(line_width);
    if (eff_w < 32'(ela_pkg::LINE_MIN)) begin
      eff_w = 32'(ela_pkg::LINE_MIN);
    end else if (eff_w > 32'(MAX_LINE)) begin
      eff_w = 32'(MAX_LINE);
    end
    col_inc = 32'(col_cur) + 32'd1;
    wrap    = col_inc >= eff_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count   <= '0;
      past_first_row <= 1'b0;
      left_pixel     <= '0;
    end else if (accept) begin
      column_count   <= wrap ? '0 : col_inc[COL_W-1:0];
      past_first_row <= first_ok || wrap;
      left_pixel     <= src_m;
    end
  end

  // line buffer: read and write at the same column on acceptance
  ela_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_LINE)
  ) u_line (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col_cur),
    .wr_data (src_m),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .rd_data (above_word)
  );

  // operand stage
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src  <= src_m;
      s1_left <= left_pixel;
      s1_dst  <= dst_word;
    end
  end

  // valid bits through operand, product and output stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v1        <= accept && produce;
      v2        <= v1;
      res_valid <= v2;
    end
  end

  assign lane_cfg.wide = wide_channels;
  assign lane_cfg.mode = direction_mode;
  assign lane_cfg.gain = $signed(strength);

  // one lane per channel
  for (genvar k = 0; k < NCH; k++) begin : g_lane
    ela_lane u_lane (
      .clk    (clk),
      .adv    (adv),
      .cfg    (lane_cfg),
      .src    (s1_src[k*16 +: 16]),
      .left   (s1_left[k*16 +: 16]),
      .above  (above_word[k*16 +: 16]),
      .dst    (s1_dst[k*16 +: 16]),
      .result (lane_out[k])
    );
  end

  // merge lane results into the result word
  assign out_ch0 = lane_out[0];
  assign out_ch1 = lane_out[1];
  assign out_ch2 = lane_out[2];
  assign out_ch3 = lane_out[3];

`ifndef SYNTHESIS
  // a producing pixel reaches the output when the pipeline does not stall
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && produce) ##1 adv ##1 adv |=> res_valid)
    else $error("producing pixel did not reach the output");

  // the first-row flag only clears on a frame start
  a_row_flag_clear: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(past_first_row)) |-> $past(accept && frame_start))
    else $error("first-row flag cleared without frame start");

  // once past the first row, plain pixels keep it so
  a_row_flag_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && !frame_start && past_first_row) |=> past_first_row)
    else $error("first-row flag lost mid-frame");

  // nothing enters the pipeline from the first column
  a_first_col: assert property (@(posedge clk) disable iff (rst)
    (accept && col_cur == '0) |=> !v1)
    else $error("first-column pixel produced a result");
`endif

endmodule

`default_nettype wire

>>> rtl/core/ela_ram.sv
`default_nettype none

module ela_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a same-address read returns the old word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ela_lane.sv
`default_nettype none

module ela_lane (
  input  wire logic              clk,
  input  wire logic              adv,
  input  wire ela_pkg::lane_cfg_t cfg,
  input  wire logic [15:0]       src,
  input  wire logic [15:0]       left,
  input  wire logic [15:0]       above,
  input  wire logic [15:0]       dst,
  output logic      [15:0]       result
);

  logic [15:0]                         src_m;
  logic [15:0]                         left_m;
  logic [15:0]                         above_m;
  logic [15:0]                         dst_m;
  logic signed [ela_pkg::DIFF_W-1:0]   s_x;
  logic signed [ela_pkg::DIFF_W-1:0]   l_x;
  logic signed [ela_pkg::DIFF_W-1:0]   a_x;
  logic signed [ela_pkg::DIFF_W-1:0]   diff;
  logic signed [ela_pkg::PROD_W-1:0]   prod;
  logic [15:0]                         dst2;
  logic signed [ela_pkg::PROD_W-1:0]   shifted;
  logic signed [ela_pkg::PROD_W:0]     sum;
  logic [15:0]                         maxv;
  logic [15:0]                         result_next;

  // Channel masking for eight-bit mode
  always_comb begin
    src_m   = cfg.wide ? src   : {8'h00, src[7:0]};
    left_m  = cfg.wide ? left  : {8'h00, left[7:0]};
    above_m = cfg.wide ? above : {8'h00, above[7:0]};
    dst_m   = cfg.wide ? dst   : {8'h00, dst[7:0]};
  end

  // Neighbor difference
  always_comb begin
    s_x = $signed({2'b00, src_m});
    l_x = $signed({2'b00, left_m});
    a_x = $signed({2'b00, above_m});
    case (cfg.mode)
      ela_pkg::DIR_H: diff = s_x - l_x;
      ela_pkg::DIR_V: diff = s_x - a_x;
      default:        diff = (s_x <<< 1) - a_x - l_x;
    endcase
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= diff * cfg.gain;
      dst2 <= dst_m;
    end
  end

  // Floor shift, accumulate, clamp
  always_comb begin
    shifted = cfg.wide ? (prod >>> 16) : (prod >>> 8);
    sum     = (ela_pkg::PROD_W+1)'(shifted)
            + $signed({{(ela_pkg::PROD_W-15){1'b0}}, dst2});
    maxv    = cfg.wide ? ela_pkg::MAX_WIDE : ela_pkg::MAX_NARROW;
    if (sum < 0) begin
      result_next = '0;
    end else if (sum > $signed({{(ela_pkg::PROD_W-15){1'b0}}, maxv})) begin
      result_next = maxv;
    end else begin
      result_next = sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire
